@@ hdl/moi_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the mecanum odometry core.
// No dependencies; every other file imports this package.
`default_nettype none
package moi_pkg;

  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned IDX_W = 5;

  // input item kinds
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_COMMAND = 1'b1;

  // register indexes on the configuration port
  localparam logic [1:0] REG_RADIUS         = 2'd0;
  localparam logic [1:0] REG_INV_TRACK_SUM  = 2'd1;
  localparam logic [1:0] REG_STEP_PERIOD    = 2'd2;
  localparam logic [1:0] REG_CMD_TIMEOUT    = 2'd3;

  localparam logic [15:0] RST_RADIUS       = 16'd2621;
  localparam logic [19:0] RST_INV_TRACK    = 20'd81920;
  localparam logic [23:0] RST_STEP_PERIOD  = 24'd335544;
  localparam logic [31:0] RST_CMD_TIMEOUT  = 32'd500000;

  // fixed-point constants
  localparam logic signed [39:0] TWO_PI_Q29  = 40'sd3373259426;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic [19:0]        TWO_PI_Q16  = 20'd411775;
  // bias that makes any heading sum nonnegative before the modulo
  localparam logic signed [26:0] WRAP_BIAS   = 27'sd9264937;
  // floor(2^32 / TWO_PI_Q16)
  localparam logic signed [24:0] WRAP_RECIP  = 25'sd10430;

  typedef enum logic [4:0] {
    S_IDLE, S_CIRC_MUL, S_CIRC_RND, S_V_MUL, S_V_RND, S_SUMS, S_WZ_MUL, S_WZ,
    S_INC_MUL, S_WRAP_IN, S_WRAP_MUL, S_WRAP_Q, S_WRAP_FIX, S_ROT_LOAD, S_ROT,
    S_XC, S_YS, S_XS, S_YC, S_RY, S_PX_MUL, S_PX, S_PY, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CMD, OP_LOAD, OP_CIRC_MUL, OP_CIRC_RND, OP_V_MUL, OP_V_RND,
    OP_SUMS, OP_WZ_MUL, OP_WZ, OP_INC_MUL, OP_WRAP_IN, OP_WRAP_MUL, OP_WRAP_Q,
    OP_WRAP_FIX, OP_ROT_LOAD, OP_ROT, OP_XC, OP_YS, OP_XS, OP_YC, OP_RY,
    OP_PX_MUL, OP_PX, OP_PY, OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  function automatic logic signed [33:0] atan_q30(input logic [IDX_W-1:0] i);
    case (i)
      5'd0:  atan_q30 = 34'sd843314856;
      5'd1:  atan_q30 = 34'sd497837829;
      5'd2:  atan_q30 = 34'sd263043836;
      5'd3:  atan_q30 = 34'sd133525158;
      5'd4:  atan_q30 = 34'sd67021686;
      5'd5:  atan_q30 = 34'sd33543515;
      5'd6:  atan_q30 = 34'sd16775850;
      5'd7:  atan_q30 = 34'sd8388437;
      5'd8:  atan_q30 = 34'sd4194282;
      5'd9:  atan_q30 = 34'sd2097149;
      5'd10: atan_q30 = 34'sd1048575;
      5'd11: atan_q30 = 34'sd524287;
      5'd12: atan_q30 = 34'sd262143;
      5'd13: atan_q30 = 34'sd131071;
      5'd14: atan_q30 = 34'sd65535;
      5'd15: atan_q30 = 34'sd32767;
      5'd16: atan_q30 = 34'sd16383;
      5'd17: atan_q30 = 34'sd8191;
      5'd18: atan_q30 = 34'sd4095;
      5'd19: atan_q30 = 34'sd2047;
      5'd20: atan_q30 = 34'sd1023;
      5'd21: atan_q30 = 34'sd511;
      5'd22: atan_q30 = 34'sd255;
      5'd23: atan_q30 = 34'sd127;
      default: atan_q30 = 34'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/moi_cordic.sv @@
// Iterative rotation-mode CORDIC, one micro-rotation per cycle while step is high, Q.30 angle in, cos/sin out.
// Depends on moi_pkg for the arctangent table and gain constants.
`default_nettype none
module moi_cordic (
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic                         step,
  input  wire logic [moi_pkg::IDX_W-1:0]    idx,
  input  wire logic signed [33:0]           angle,
  output logic signed [33:0]                cos_out,
  output logic signed [33:0]                sin_out
);
  import moi_pkg::*;

  logic signed [33:0] x, y, z;
  logic               neg;
  logic signed [33:0] dx, dy;

  assign dx = y >>> idx;
  assign dy = x >>> idx;

  always_ff @(posedge clk) begin
    if (load) begin
      x <= GAIN_Q30;
      y <= '0;
      // fold angles beyond a quarter turn, negate at the end
      if (angle > HALF_PI_Q30) begin
        z   <= angle - PI_Q30;
        neg <= 1'b1;
      end else if (angle < -HALF_PI_Q30) begin
        z   <= angle + PI_Q30;
        neg <= 1'b1;
      end else begin
        z   <= angle;
        neg <= 1'b0;
      end
    end else if (step) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_q30(idx);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_q30(idx);
      end
    end
  end

  assign cos_out = neg ? -x : x;
  assign sin_out = neg ? -y : y;

endmodule
`default_nettype wire

@@ hdl/moi_ctrl.sv @@
// Sequencer for the odometry core: steps the datapath through one tick and runs the handshakes.
// Depends on moi_pkg for the state, operation and command types.
`default_nettype none
module moi_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            cmd,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output moi_pkg::dp_cmd_t     dp_cmd
);
  import moi_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    out_valid_next = out_valid && out_stall;
    dp_cmd.op      = OP_NONE;
    dp_cmd.idx     = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_COMMAND) begin
            dp_cmd.op = OP_CMD;
          end else begin
            dp_cmd.op  = OP_LOAD;
            state_next = S_CIRC_MUL;
          end
        end
      end
      S_CIRC_MUL: begin
        dp_cmd.op  = OP_CIRC_MUL;
        state_next = S_CIRC_RND;
      end
      S_CIRC_RND: begin
        dp_cmd.op  = OP_CIRC_RND;
        idx_next   = '0;
        state_next = S_V_MUL;
      end
      S_V_MUL: begin
        dp_cmd.op  = OP_V_MUL;
        state_next = S_V_RND;
      end
      S_V_RND: begin
        dp_cmd.op = OP_V_RND;
        idx_next  = idx + 1'b1;
        if (idx == IDX_W'(3)) begin
          state_next = S_SUMS;
        end else begin
          state_next = S_V_MUL;
        end
      end
      S_SUMS: begin
        dp_cmd.op  = OP_SUMS;
        state_next = S_WZ_MUL;
      end
      S_WZ_MUL: begin
        dp_cmd.op  = OP_WZ_MUL;
        state_next = S_WZ;
      end
      S_WZ: begin
        dp_cmd.op  = OP_WZ;
        state_next = S_INC_MUL;
      end
      S_INC_MUL: begin
        dp_cmd.op  = OP_INC_MUL;
        state_next = S_WRAP_IN;
      end
      S_WRAP_IN: begin
        dp_cmd.op  = OP_WRAP_IN;
        state_next = S_WRAP_MUL;
      end
      S_WRAP_MUL: begin
        dp_cmd.op  = OP_WRAP_MUL;
        state_next = S_WRAP_Q;
      end
      S_WRAP_Q: begin
        dp_cmd.op  = OP_WRAP_Q;
        state_next = S_WRAP_FIX;
      end
      S_WRAP_FIX: begin
        dp_cmd.op  = OP_WRAP_FIX;
        state_next = S_ROT_LOAD;
      end
      S_ROT_LOAD: begin
        dp_cmd.op  = OP_ROT_LOAD;
        idx_next   = '0;
        state_next = S_ROT;
      end
      S_ROT: begin
        dp_cmd.op = OP_ROT;
        idx_next  = idx + 1'b1;
        if (idx == IDX_W'(CORDIC_STEPS - 1)) begin
          state_next = S_XC;
        end
      end
      S_XC: begin
        dp_cmd.op  = OP_XC;
        state_next = S_YS;
      end
      S_YS: begin
        dp_cmd.op  = OP_YS;
        state_next = S_XS;
      end
      S_XS: begin
        dp_cmd.op  = OP_XS;
        state_next = S_YC;
      end
      S_YC: begin
        dp_cmd.op  = OP_YC;
        state_next = S_RY;
      end
      S_RY: begin
        dp_cmd.op  = OP_RY;
        state_next = S_PX_MUL;
      end
      S_PX_MUL: begin
        dp_cmd.op  = OP_PX_MUL;
        state_next = S_PX;
      end
      S_PX: begin
        dp_cmd.op  = OP_PX;
        state_next = S_PY;
      end
      S_PY: begin
        dp_cmd.op  = OP_PY;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free or being taken
        if (!out_valid || !out_stall) begin
          dp_cmd.op      = OP_PUBLISH;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/moi_datapath.sv @@
// Datapath of the odometry core: config registers, pose state, shared multiplier, heading wrap,
// two CORDIC units and the output word register. Depends on moi_pkg and moi_cordic.
`default_nettype none
module moi_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  moi_pkg::dp_cmd_t         dp_cmd,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic [47:0]         now_us,
  input  wire logic signed [23:0]  speed_front_left,
  input  wire logic signed [23:0]  speed_front_right,
  input  wire logic signed [23:0]  speed_rear_left,
  input  wire logic signed [23:0]  speed_rear_right,
  input  wire logic                imu_yaw_valid,
  input  wire logic signed [19:0]  imu_yaw,
  input  wire logic                estop_active,
  output logic signed [31:0]       position_x,
  output logic signed [31:0]       position_y,
  output logic signed [19:0]       heading,
  output logic signed [15:0]       orient_z,
  output logic signed [15:0]       orient_w,
  output logic signed [23:0]       body_vel_x,
  output logic signed [23:0]       body_vel_y,
  output logic signed [23:0]       yaw_rate,
  output logic                     stop_motors
);
  import moi_pkg::*;

  function automatic logic signed [74:0] rnd75(input logic signed [74:0] t, input int s);
    rnd75 = (t + (75'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] t);
    if (t > 64'sd8388607) sat24 = 24'sh7FFFFF;
    else if (t < -64'sd8388608) sat24 = 24'sh800000;
    else sat24 = t[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] t);
    if (t > 64'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (t < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = t[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] t);
    if (t > 64'sd32767) sat16 = 16'sh7FFF;
    else if (t < -64'sd32768) sat16 = 16'sh8000;
    else sat16 = t[15:0];
  endfunction

  // configuration and persistent state
  logic [15:0]        radius_q16;
  logic [19:0]        inv_four_track_sum;
  logic [23:0]        step_period;
  logic [31:0]        command_timeout_us;
  logic [47:0]        last_command_time;
  logic signed [31:0] pose_x, pose_y;
  logic signed [19:0] pose_heading;

  // per-tick working registers
  logic signed [23:0] sp [4];
  logic               imu_valid_r;
  logic signed [19:0] imu_yaw_r;
  logic               stop_r;
  logic signed [74:0] prod, acc;
  logic [27:0]        circ;
  logic signed [35:0] v [4];
  logic signed [23:0] vx, vy, wz;
  logic signed [38:0] dz;
  logic [24:0]        wrap_u;
  logic [19:0]        wrap_r;
  logic signed [25:0] rate_x, rate_y;
  logic signed [15:0] oz, ow;

  // shared multiplier operands: wide term on a, short term on b
  logic signed [39:0] mul_a;
  logic signed [24:0] mul_b;

  logic signed [33:0] cos_a, sin_a, cos_b, sin_b;
  logic signed [33:0] ang_a, ang_b;
  logic               rot_load, rot_step;

  logic signed [63:0] vsum, vdiff;
  logic signed [26:0] hsum;
  logic [6:0]         wrap_q;
  logic [25:0]        wrap_diff;
  logic [19:0]        wrap_c;
  logic signed [20:0] wrap_h;
  logic signed [63:0] px_sum, py_sum;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (dp_cmd.op)
      OP_CIRC_MUL: begin
        mul_a = TWO_PI_Q29;
        mul_b = 25'(radius_q16);
      end
      OP_V_MUL: begin
        mul_a = 40'(circ);
        mul_b = 25'(sp[dp_cmd.idx[1:0]]);
      end
      OP_WZ_MUL: begin
        mul_a = 40'(dz);
        mul_b = 25'(inv_four_track_sum);
      end
      OP_INC_MUL: begin
        mul_a = 40'(wz);
        mul_b = 25'(step_period);
      end
      OP_WRAP_MUL: begin
        mul_a = 40'(wrap_u);
        mul_b = WRAP_RECIP;
      end
      OP_XC: begin
        mul_a = 40'(cos_a);
        mul_b = 25'(vx);
      end
      OP_YS: begin
        mul_a = 40'(sin_a);
        mul_b = 25'(vy);
      end
      OP_XS: begin
        mul_a = 40'(sin_a);
        mul_b = 25'(vx);
      end
      OP_YC: begin
        mul_a = 40'(cos_a);
        mul_b = 25'(vy);
      end
      OP_PX_MUL: begin
        mul_a = 40'(rate_x);
        mul_b = 25'(step_period);
      end
      OP_PX: begin
        mul_a = 40'(rate_y);
        mul_b = 25'(step_period);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign vsum  = 64'(v[0]) + 64'(v[1]) + 64'(v[2]) + 64'(v[3]);
  assign vdiff = -64'(v[0]) + 64'(v[1]) + 64'(v[2]) - 64'(v[3]);

  assign hsum = imu_valid_r ? 27'(imu_yaw_r)
                            : 27'(pose_heading) + 27'(rnd75(prod, 24));
  assign wrap_q    = prod[38:32];
  assign wrap_diff = 26'(wrap_u) - 26'(wrap_q) * 26'(TWO_PI_Q16);
  assign wrap_c    = (wrap_r >= TWO_PI_Q16) ? wrap_r - TWO_PI_Q16 : wrap_r;
  assign wrap_h    = $signed({1'b0, wrap_c}) - PI_Q16;

  assign px_sum = 64'(pose_x) + 64'(rnd75(prod, 24));
  assign py_sum = 64'(pose_y) + 64'(rnd75(prod, 24));

  assign ang_a    = {pose_heading, 14'd0};
  assign ang_b    = {pose_heading[19], pose_heading, 13'd0};
  assign rot_load = (dp_cmd.op == OP_ROT_LOAD);
  assign rot_step = (dp_cmd.op == OP_ROT);

  moi_cordic u_cordic_full (
    .clk     (clk),
    .load    (rot_load),
    .step    (rot_step),
    .idx     (dp_cmd.idx),
    .angle   (ang_a),
    .cos_out (cos_a),
    .sin_out (sin_a)
  );

  moi_cordic u_cordic_half (
    .clk     (clk),
    .load    (rot_load),
    .step    (rot_step),
    .idx     (dp_cmd.idx),
    .angle   (ang_b),
    .cos_out (cos_b),
    .sin_out (sin_b)
  );

  // registers with a reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_q16         <= RST_RADIUS;
      inv_four_track_sum <= RST_INV_TRACK;
      step_period        <= RST_STEP_PERIOD;
      command_timeout_us <= RST_CMD_TIMEOUT;
      last_command_time  <= '0;
      pose_x             <= '0;
      pose_y             <= '0;
      pose_heading       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RADIUS:        radius_q16         <= cfg_data[15:0];
          REG_INV_TRACK_SUM: inv_four_track_sum <= cfg_data[19:0];
          REG_STEP_PERIOD:   step_period        <= cfg_data[23:0];
          REG_CMD_TIMEOUT:   command_timeout_us <= cfg_data;
          default: begin
          end
        endcase
      end
      case (dp_cmd.op)
        OP_CMD: begin
          // an estopped command leaves the timer alone
          if (!estop_active) begin
            last_command_time <= now_us;
          end
        end
        OP_WRAP_FIX: pose_heading <= wrap_h[19:0];
        OP_PX:       pose_x       <= sat32(px_sum);
        OP_PY:       pose_y       <= sat32(py_sum);
        default: begin
        end
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (dp_cmd.op)
      OP_LOAD: begin
        sp[0]       <= speed_front_left;
        sp[1]       <= speed_front_right;
        sp[2]       <= speed_rear_left;
        sp[3]       <= speed_rear_right;
        imu_valid_r <= imu_yaw_valid;
        imu_yaw_r   <= imu_yaw;
        stop_r      <= (last_command_time != '0) &&
                       ((now_us - last_command_time) > 48'(command_timeout_us));
      end
      OP_CIRC_RND: circ <= 28'(rnd75(prod, 21));
      OP_V_RND:    v[dp_cmd.idx[1:0]] <= 36'(rnd75(prod, 16));
      OP_SUMS: begin
        vx <= sat24(64'(rnd75(75'(vsum), 10)));
        vy <= sat24(64'(rnd75(75'(vdiff), 10)));
        dz <= 39'(-64'(v[0]) + 64'(v[1]) - 64'(v[2]) + 64'(v[3]));
      end
      OP_WZ:      wz     <= sat24(64'(rnd75(prod, 24)));
      OP_WRAP_IN: wrap_u <= 25'(hsum + WRAP_BIAS);
      OP_WRAP_Q:  wrap_r <= wrap_diff[19:0];
      OP_YS:      acc    <= prod;
      OP_XS:      rate_x <= 26'(rnd75(acc - prod, 30));
      OP_YC:      acc    <= prod;
      OP_RY:      rate_y <= 26'(rnd75(acc + prod, 30));
      OP_PY: begin
        oz <= sat16(64'(rnd75(75'(sin_b), 15)));
        ow <= sat16(64'(rnd75(75'(cos_b), 15)));
      end
      OP_PUBLISH: begin
        position_x  <= pose_x;
        position_y  <= pose_y;
        heading     <= pose_heading;
        orient_z    <= oz;
        orient_w    <= ow;
        body_vel_x  <= vx;
        body_vel_y  <= vy;
        yaw_rate    <= wz;
        stop_motors <= stop_r;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/mecanum_odometry_integrator_core.sv @@
// Mecanum odometry core: a tick word is accepted when idle and its result word shows once the
// shared multiplier sequence and the one-step-per-cycle CORDIC iterations are through and the
// output register is free; no new word is taken until the tick's result word is published.
// A command word is taken while idle and gives no result word.
// Synchronous reset clears pose, command time, handshake state and restores register defaults.
`default_nettype none
module mecanum_odometry_integrator_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                cmd,
  input  wire logic [47:0]         now_us,
  input  wire logic signed [23:0]  speed_front_left,
  input  wire logic signed [23:0]  speed_front_right,
  input  wire logic signed [23:0]  speed_rear_left,
  input  wire logic signed [23:0]  speed_rear_right,
  input  wire logic                imu_yaw_valid,
  input  wire logic signed [19:0]  imu_yaw,
  input  wire logic                estop_active,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       position_x,
  output logic signed [31:0]       position_y,
  output logic signed [19:0]       heading,
  output logic signed [15:0]       orient_z,
  output logic signed [15:0]       orient_w,
  output logic signed [23:0]       body_vel_x,
  output logic signed [23:0]       body_vel_y,
  output logic signed [23:0]       yaw_rate,
  output logic                     stop_motors
);
  import moi_pkg::*;

  dp_cmd_t dp_cmd;

  moi_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  moi_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .dp_cmd            (dp_cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .now_us            (now_us),
    .speed_front_left  (speed_front_left),
    .speed_front_right (speed_front_right),
    .speed_rear_left   (speed_rear_left),
    .speed_rear_right  (speed_rear_right),
    .imu_yaw_valid     (imu_yaw_valid),
    .imu_yaw           (imu_yaw),
    .estop_active      (estop_active),
    .position_x        (position_x),
    .position_y        (position_y),
    .heading           (heading),
    .orient_z          (orient_z),
    .orient_w          (orient_w),
    .body_vel_x        (body_vel_x),
    .body_vel_y        (body_vel_y),
    .yaw_rate          (yaw_rate),
    .stop_motors       (stop_motors)
  );

endmodule
`default_nettype wire
